// ===== rtl/sdh_pkg.sv =====
package sdh_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int BOOT_DUMMY_BYTES = 10;
	localparam int IDX_W = $clog2(BLOCK_BYTES + 1);

	typedef enum logic [2:0] {
		REG_RESPONSE_POLLS = 3'd0,
		REG_READY_POLLS    = 3'd1,
		REG_OP_COND_POLLS  = 3'd2,
		REG_TOKEN_POLLS    = 3'd3,
		REG_BUSY_POLLS     = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		MODE_SLOT  = 2'd0,
		MODE_INIT  = 2'd1,
		MODE_READ  = 2'd2,
		MODE_WRITE = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_BOOT, PH_READY, PH_FRAME, PH_RESP, PH_R7, PH_OCR,
		PH_RTOKEN, PH_RDATA, PH_RCRC, PH_WTOKEN, PH_WDATA, PH_WCRC,
		PH_WRESP, PH_WBUSY
	} phase_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [31:0] block_address;
		logic [7:0] miso_byte;
		logic [7:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [7:0] mosi_byte;
		logic select_low;
		logic fast_clock;
		logic [7:0] read_data;
		logic read_valid;
		logic write_data_taken;
		logic done_res;
		logic success;
		logic [1:0] card_kind;
		logic [4:0] diag_bits;
		logic [7:0] reset_response;
	} out_item_t;

	typedef struct packed {
		logic [7:0] response_polls;
		logic [19:0] ready_polls;
		logic [15:0] op_cond_polls;
		logic [19:0] token_polls;
		logic [19:0] busy_polls;
	} cfg_t;

endpackage

// ===== rtl/sdh_in_if.sv =====
interface sdh_in_if;
	import sdh_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic [31:0] block_address;
	logic [7:0] miso_byte;
	logic [7:0] write_data;
	modport source (output valid, mode, block_address, miso_byte, write_data, input ready);
	modport sink (input valid, mode, block_address, miso_byte, write_data, output ready);
endinterface

// ===== rtl/sdh_out_if.sv =====
interface sdh_out_if;
	logic valid;
	logic ready;
	logic [7:0] mosi_byte;
	logic select_low;
	logic fast_clock;
	logic [7:0] read_data;
	logic read_valid;
	logic write_data_taken;
	logic done_res;
	logic success;
	logic [1:0] card_kind;
	logic [4:0] diag_bits;
	logic [7:0] reset_response;
	modport source (output valid, mosi_byte, select_low, fast_clock, read_data, read_valid,
		write_data_taken, done_res, success, card_kind, diag_bits, reset_response,
		input ready);
	modport sink (input valid, mosi_byte, select_low, fast_clock, read_data, read_valid,
		write_data_taken, done_res, success, card_kind, diag_bits, reset_response,
		output ready);
endinterface

// ===== rtl/sdh_front.sv =====
module sdh_front (
	input  logic clk,
	input  logic arst_n,
	sdh_in_if.sink in_ch,
	output sdh_pkg::in_item_t item,
	output logic item_valid,
	input  logic item_ready
);
	import sdh_pkg::*;

	// two-entry queue of accepted input beats
	in_item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign item_valid = (cnt_q != 2'd0);
	assign pop = item_valid && item_ready;
	assign item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{mode: in_ch.mode, block_address: in_ch.block_address,
				miso_byte: in_ch.miso_byte, write_data: in_ch.write_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/sdh_back.sv =====
module sdh_back (
	input  logic clk,
	input  logic arst_n,
	input  sdh_pkg::cfg_t cfg,
	input  sdh_pkg::in_item_t item,
	input  logic item_valid,
	output logic item_ready,
	sdh_out_if.source out_ch
);
	import sdh_pkg::*;

	phase_t phase_q, phase_d;
	logic [19:0] poll_q, poll_d;
	logic [15:0] att_q, att_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [31:0] arg_q, arg_d;
	logic [5:0] cmd_q, cmd_d;
	logic [31:0] reply_q, reply_d;
	logic [7:0] r1_q, r1_d;
	logic [1:0] ctype_q, ctype_d;
	logic v2_q, v2_d;
	logic [4:0] diag_q, diag_d;
	logic [7:0] c0_q, c0_d;
	out_item_t res, res_q;
	logic ovalid_q, step;

	logic [19:0] lim_resp, lim_ready, lim_tok, lim_busy;
	logic [15:0] lim_op;
	logic [7:0] miso;
	logic slow, rw, initp, done_cmd;
	logic [31:0] nreply;

	assign step = item_valid && (!ovalid_q || out_ch.ready);
	assign item_ready = step;
	assign miso = item.miso_byte;
	assign lim_resp = (cfg.response_polls == 8'd0) ? 20'd1 : {12'd0, cfg.response_polls};
	assign lim_ready = (cfg.ready_polls == 20'd0) ? 20'd1 : cfg.ready_polls;
	assign lim_tok = (cfg.token_polls == 20'd0) ? 20'd1 : cfg.token_polls;
	assign lim_busy = (cfg.busy_polls == 20'd0) ? 20'd1 : cfg.busy_polls;
	assign lim_op = (cfg.op_cond_polls == 16'd0) ? 16'd1 : cfg.op_cond_polls;
	assign nreply = {reply_q[23:0], miso};

	function automatic logic [7:0] frame_byte(input logic [IDX_W-1:0] i, input logic [5:0] c,
		input logic [31:0] a);
		logic [7:0] b;
		case (i)
			IDX_W'(0): b = {2'b01, c};
			IDX_W'(1): b = a[31:24];
			IDX_W'(2): b = a[23:16];
			IDX_W'(3): b = a[15:8];
			IDX_W'(4): b = a[7:0];
			default: b = (c == 6'd0) ? 8'h95 : (c == 6'd8) ? 8'h87 : 8'h01;
		endcase
		return b;
	endfunction

	always_comb begin
		phase_d = phase_q; poll_d = poll_q; att_d = att_q; idx_d = idx_q; arg_d = arg_q;
		cmd_d = cmd_q; reply_d = reply_q; r1_d = r1_q; ctype_d = ctype_q; v2_d = v2_q;
		diag_d = diag_q; c0_d = c0_q;
		res = '0;
		res.mosi_byte = 8'hFF;
		slow = 1'b0;
		done_cmd = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (item.mode == MODE_INIT) begin
					ctype_d = 2'd0; diag_d = '0; c0_d = 8'hFF; v2_d = 1'b0; cmd_d = 6'd0;
					idx_d = IDX_W'(1); phase_d = PH_BOOT;
				end else if (item.mode == MODE_READ || item.mode == MODE_WRITE) begin
					if (ctype_q == 2'd0) begin
						res.done_res = 1'b1; slow = (cmd_q == 6'd17 || cmd_q == 6'd24);
						slow = !slow;
					end else begin
						cmd_d = (item.mode == MODE_READ) ? 6'd17 : 6'd24;
						arg_d = (ctype_q == 2'd2) ? item.block_address
							: {item.block_address[22:0], 9'd0};
						poll_d = 20'd1; phase_d = PH_READY;
					end
				end
			end
			PH_BOOT: begin
				if (idx_q < IDX_W'(BOOT_DUMMY_BYTES)) idx_d = idx_q + 1'b1;
				else begin
					cmd_d = 6'd0; arg_d = '0; poll_d = 20'd1; phase_d = PH_READY;
				end
			end
			PH_READY: begin
				if (miso == 8'hFF || poll_q >= lim_ready) begin
					idx_d = '0; res.mosi_byte = frame_byte('0, cmd_q, arg_q);
					phase_d = PH_FRAME;
				end else poll_d = poll_q + 1'b1;
			end
			PH_FRAME: begin
				if (idx_q < IDX_W'(5)) begin
					idx_d = idx_q + 1'b1;
					res.mosi_byte = frame_byte(idx_q + 1'b1, cmd_q, arg_q);
				end else begin
					poll_d = 20'd1; phase_d = PH_RESP;
				end
			end
			PH_RESP: begin
				if (!miso[7] || poll_q >= lim_resp) done_cmd = 1'b1;
				else poll_d = poll_q + 1'b1;
			end
			PH_R7: begin
				reply_d = nreply;
				if (idx_q < IDX_W'(3)) idx_d = idx_q + 1'b1;
				else begin
					v2_d = (nreply[15:0] == 16'h01AA);
					if (nreply[15:0] == 16'h01AA) diag_d = diag_q | 5'h02;
					att_d = 16'd1; cmd_d = 6'd55; arg_d = '0; poll_d = 20'd1;
					phase_d = PH_READY;
				end
			end
			PH_OCR: begin
				reply_d = nreply;
				if (idx_q < IDX_W'(3)) idx_d = idx_q + 1'b1;
				else begin
					if (r1_q == 8'd0) diag_d = diag_q | 5'h10;
					if (r1_q == 8'd0 && nreply[30]) begin
						ctype_d = 2'd2; res.done_res = 1'b1; res.success = 1'b1;
						slow = 1'b1; phase_d = PH_IDLE;
					end else begin
						ctype_d = 2'd1; cmd_d = 6'd16; arg_d = 32'd512; poll_d = 20'd1;
						phase_d = PH_READY;
					end
				end
			end
			PH_RTOKEN: begin
				if (miso != 8'hFF) begin
					if (miso == 8'hFE) begin
						idx_d = '0; phase_d = PH_RDATA;
					end else res.done_res = 1'b1;
				end else if (poll_q >= lim_tok) res.done_res = 1'b1;
				else poll_d = poll_q + 1'b1;
			end
			PH_RDATA: begin
				res.read_data = miso; res.read_valid = 1'b1;
				if (idx_q + 1'b1 >= IDX_W'(BLOCK_BYTES)) begin
					idx_d = '0; phase_d = PH_RCRC;
				end else idx_d = idx_q + 1'b1;
			end
			PH_RCRC: begin
				if (idx_q == '0) idx_d = IDX_W'(1);
				else begin
					res.done_res = 1'b1; res.success = 1'b1;
				end
			end
			PH_WTOKEN: begin
				res.mosi_byte = item.write_data; idx_d = IDX_W'(1);
				res.write_data_taken = 1'b1; phase_d = PH_WDATA;
			end
			PH_WDATA: begin
				if (idx_q < IDX_W'(BLOCK_BYTES)) begin
					res.mosi_byte = item.write_data; idx_d = idx_q + 1'b1;
					res.write_data_taken = (idx_q + 1'b1 < IDX_W'(BLOCK_BYTES));
				end else begin
					idx_d = '0; phase_d = PH_WCRC;
				end
			end
			PH_WCRC: begin
				if (idx_q == '0) idx_d = IDX_W'(1);
				else phase_d = PH_WRESP;
			end
			PH_WRESP: begin
				if (miso[4:0] != 5'h05) res.done_res = 1'b1;
				else begin
					poll_d = 20'd1; phase_d = PH_WBUSY;
				end
			end
			PH_WBUSY: begin
				if (miso == 8'hFF) begin
					res.done_res = 1'b1; res.success = 1'b1;
				end else if (poll_q >= lim_busy) res.done_res = 1'b1;
				else poll_d = poll_q + 1'b1;
			end
			default: phase_d = PH_IDLE;
		endcase

		if (done_cmd) begin
			r1_d = miso;
			case (cmd_q)
				6'd0: begin
					c0_d = miso;
					if (miso != 8'h01) begin
						res.done_res = 1'b1; slow = 1'b1;
					end else begin
						diag_d = diag_d | 5'h01;
						cmd_d = 6'd8; arg_d = 32'h1AA; poll_d = 20'd1; phase_d = PH_READY;
					end
				end
				6'd8: begin
					if (miso == 8'h01) begin
						reply_d = '0; idx_d = '0; phase_d = PH_R7;
					end else begin
						v2_d = 1'b0; att_d = 16'd1; cmd_d = 6'd55; arg_d = '0;
						poll_d = 20'd1; phase_d = PH_READY;
					end
				end
				6'd55: begin
					cmd_d = 6'd41; arg_d = v2_q ? 32'h4000_0000 : 32'd0;
					poll_d = 20'd1; phase_d = PH_READY;
				end
				6'd41: begin
					poll_d = 20'd1; phase_d = PH_READY;
					if (miso == 8'd0) begin
						diag_d = diag_d | 5'h04;
						if (v2_q) begin
							cmd_d = 6'd58; arg_d = '0;
						end else begin
							ctype_d = 2'd1; cmd_d = 6'd16; arg_d = 32'd512;
						end
					end else if (miso[7:1] != 7'd0 || att_q >= lim_op) begin
						att_d = 16'd1; cmd_d = 6'd1; arg_d = '0;
					end else begin
						att_d = att_q + 1'b1; cmd_d = 6'd55; arg_d = '0;
					end
				end
				6'd1: begin
					if (miso == 8'd0) begin
						diag_d = diag_d | 5'h08; ctype_d = 2'd3; cmd_d = 6'd16;
						arg_d = 32'd512; poll_d = 20'd1; phase_d = PH_READY;
					end else if (miso[7:1] != 7'd0 || att_q >= lim_op) begin
						res.done_res = 1'b1; slow = 1'b1;
					end else begin
						att_d = att_q + 1'b1; arg_d = '0; poll_d = 20'd1;
						phase_d = PH_READY;
					end
				end
				6'd58: begin
					reply_d = '0; idx_d = '0; phase_d = PH_OCR;
				end
				6'd16: begin
					res.done_res = 1'b1; res.success = 1'b1; slow = 1'b1;
				end
				6'd17: begin
					if (miso != 8'd0) res.done_res = 1'b1;
					else begin
						poll_d = 20'd1; phase_d = PH_RTOKEN;
					end
				end
				6'd24: begin
					if (miso != 8'd0) res.done_res = 1'b1;
					else begin
						res.mosi_byte = 8'hFE; res.write_data_taken = 1'b1;
						phase_d = PH_WTOKEN;
					end
				end
				default: begin
					res.done_res = 1'b1; slow = 1'b1;
				end
			endcase
		end

		if (res.done_res) begin
			res.mosi_byte = 8'hFF; phase_d = PH_IDLE;
		end
		rw = (cmd_d == 6'd17 || cmd_d == 6'd24);
		initp = (phase_d == PH_BOOT || phase_d == PH_R7 || phase_d == PH_OCR) ||
			((phase_d == PH_READY || phase_d == PH_FRAME || phase_d == PH_RESP) && !rw);
		res.select_low = (phase_d != PH_IDLE && phase_d != PH_BOOT);
		res.fast_clock = (ctype_d != 2'd0) && !initp && !slow;
		res.card_kind = ctype_d;
		res.diag_bits = diag_d;
		res.reset_response = c0_d;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res; poll_q <= poll_d; att_q <= att_d; idx_q <= idx_d; arg_q <= arg_d;
			reply_q <= reply_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0; phase_q <= PH_IDLE; cmd_q <= '0; r1_q <= 8'hFF;
			ctype_q <= '0; v2_q <= 1'b0; diag_q <= '0; c0_q <= 8'hFF;
		end else begin
			if (step) begin
				ovalid_q <= 1'b1; phase_q <= phase_d; cmd_q <= cmd_d; r1_q <= r1_d;
				ctype_q <= ctype_d; v2_q <= v2_d; diag_q <= diag_d; c0_q <= c0_d;
			end else if (out_ch.ready) ovalid_q <= 1'b0;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.mosi_byte = res_q.mosi_byte;
	assign out_ch.select_low = res_q.select_low;
	assign out_ch.fast_clock = res_q.fast_clock;
	assign out_ch.read_data = res_q.read_data;
	assign out_ch.read_valid = res_q.read_valid;
	assign out_ch.write_data_taken = res_q.write_data_taken;
	assign out_ch.done_res = res_q.done_res;
	assign out_ch.success = res_q.success;
	assign out_ch.card_kind = res_q.card_kind;
	assign out_ch.diag_bits = res_q.diag_bits;
	assign out_ch.reset_response = res_q.reset_response;
endmodule

// ===== rtl/sd_spi_mode_host_sequencer.sv =====
// SD/MMC SPI-mode host sequencer: each input beat is one byte slot (the byte the card
// returned, or an init/read/write request while idle) and yields one result beat with the
// next byte to send, chip select and clock select. One beat per clock is sustained while
// the output is ready; the back-end state machine picks the next byte, and a two-entry
// input queue plus an output register keep input and output stalls apart.
module sd_spi_mode_host_sequencer (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [19:0] cfg_data,
	sdh_in_if.sink in_ch,
	sdh_out_if.source out_ch
);
	import sdh_pkg::*;

	cfg_t cfg_q;
	in_item_t item;
	logic item_valid, item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{response_polls: 8'd16, ready_polls: 20'd200000,
				op_cond_polls: 16'd2000, token_polls: 20'd200000, busy_polls: 20'd500000};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESPONSE_POLLS: cfg_q.response_polls <= cfg_data[7:0];
				REG_READY_POLLS: cfg_q.ready_polls <= cfg_data;
				REG_OP_COND_POLLS: cfg_q.op_cond_polls <= cfg_data[15:0];
				REG_TOKEN_POLLS: cfg_q.token_polls <= cfg_data;
				REG_BUSY_POLLS: cfg_q.busy_polls <= cfg_data;
				default: ;
			endcase
		end
	end

	sdh_front u_front (.clk, .arst_n, .in_ch, .item, .item_valid, .item_ready);
	sdh_back u_back (.clk, .arst_n, .cfg(cfg_q), .item, .item_valid, .item_ready, .out_ch);
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import sdh_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;

	sdh_in_if in_ch ();
	sdh_out_if out_ch ();

	sd_spi_mode_host_sequencer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// sequencer model state
	cfg_t cfg;
	phase_t ph;
	int unsigned poll_cnt, attempt_cnt, byte_idx, cmd_arg, reply_word;
	logic [5:0] cmd_idx;
	logic [7:0] last_r1, cmd0_r1;
	logic [1:0] kind;
	logic v2;
	logic [4:0] diag;
	logic [7:0] o_mosi, o_rdata;
	logic o_done, o_ok, o_rvalid, o_take, o_slow;

	int card_profile;  // 0 sdhc, 1 sd v2 byte, 2 sd v1, 3 mmc, 4 dead
	in_item_t slot_q[$];
	out_item_t mosi_q[$];
	int errors = 0;

	function automatic int unsigned at_least_one(int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic logic is_rw();
		return cmd_idx == 6'd17 || cmd_idx == 6'd24;
	endfunction

	function automatic void end_request(logic ok);
		o_mosi = 8'hFF;
		o_done = 1'b1;
		o_ok = ok;
		o_slow = !is_rw();
		ph = PH_IDLE;
	endfunction

	function automatic void issue_cmd(logic [5:0] c, logic [31:0] a);
		cmd_idx = c;
		cmd_arg = a;
		o_mosi = 8'hFF;
		poll_cnt = 1;
		ph = PH_READY;
	endfunction

	function automatic logic [7:0] frame_at(int unsigned i);
		if (i == 0) return 8'h40 | {2'b00, cmd_idx};
		if (i <= 4) return 8'(cmd_arg >> (8 * (4 - i)));
		if (cmd_idx == 6'd0) return 8'h95;
		if (cmd_idx == 6'd8) return 8'h87;
		return 8'h01;
	endfunction

	function automatic void on_r1(logic [7:0] r1);
		last_r1 = r1;
		case (cmd_idx)
			6'd0: begin
				cmd0_r1 = r1;
				if (r1 != 8'h01) end_request(1'b0);
				else begin
					diag |= 5'h01;
					issue_cmd(6'd8, 32'h1AA);
				end
			end
			6'd8: begin
				if (r1 == 8'h01) begin
					reply_word = 0; byte_idx = 0; o_mosi = 8'hFF; ph = PH_R7;
				end else begin
					v2 = 1'b0; attempt_cnt = 1; issue_cmd(6'd55, 0);
				end
			end
			6'd55: issue_cmd(6'd41, v2 ? 32'h4000_0000 : 32'h0);
			6'd41: begin
				if (r1 == 8'h00) begin
					diag |= 5'h04;
					if (v2) issue_cmd(6'd58, 0);
					else begin
						kind = 2'd1; issue_cmd(6'd16, 512);
					end
				end else if ((r1 & 8'hFE) != 0 ||
						attempt_cnt >= at_least_one(cfg.op_cond_polls)) begin
					attempt_cnt = 1; issue_cmd(6'd1, 0);
				end else begin
					attempt_cnt++; issue_cmd(6'd55, 0);
				end
			end
			6'd1: begin
				if (r1 == 8'h00) begin
					diag |= 5'h08; kind = 2'd3; issue_cmd(6'd16, 512);
				end else if ((r1 & 8'hFE) != 0 ||
						attempt_cnt >= at_least_one(cfg.op_cond_polls)) begin
					end_request(1'b0);
				end else begin
					attempt_cnt++; issue_cmd(6'd1, 0);
				end
			end
			6'd58: begin
				reply_word = 0; byte_idx = 0; o_mosi = 8'hFF; ph = PH_OCR;
			end
			6'd16: end_request(1'b1);
			6'd17: begin
				if (r1 != 8'h00) end_request(1'b0);
				else begin
					o_mosi = 8'hFF; poll_cnt = 1; ph = PH_RTOKEN;
				end
			end
			6'd24: begin
				if (r1 != 8'h00) end_request(1'b0);
				else begin
					o_mosi = 8'hFE; o_take = 1'b1; ph = PH_WTOKEN;
				end
			end
			default: end_request(1'b0);
		endcase
	endfunction

	function automatic logic in_init();
		if (ph == PH_BOOT || ph == PH_R7 || ph == PH_OCR) return 1'b1;
		if (ph == PH_READY || ph == PH_FRAME || ph == PH_RESP) return !is_rw();
		return 1'b0;
	endfunction

	function automatic out_item_t next_slot(in_item_t it);
		out_item_t r;
		o_mosi = 8'hFF; o_done = 0; o_ok = 0; o_rdata = 0; o_rvalid = 0; o_take = 0; o_slow = 0;
		case (ph)
			PH_IDLE: begin
				if (it.mode == MODE_INIT) begin
					kind = 0; diag = 0; cmd0_r1 = 8'hFF; v2 = 0; cmd_idx = 0;
					byte_idx = 1; ph = PH_BOOT;
				end else if (it.mode == MODE_READ || it.mode == MODE_WRITE) begin
					if (kind == 0) end_request(1'b0);
					else issue_cmd(it.mode == MODE_READ ? 6'd17 : 6'd24,
						kind == 2'd2 ? it.block_address : it.block_address * 32'd512);
				end
			end
			PH_BOOT: begin
				if (byte_idx < BOOT_DUMMY_BYTES) byte_idx++;
				else issue_cmd(6'd0, 0);
			end
			PH_READY: begin
				if (it.miso_byte == 8'hFF || poll_cnt >= at_least_one(cfg.ready_polls)) begin
					byte_idx = 0; o_mosi = frame_at(0); ph = PH_FRAME;
				end else poll_cnt++;
			end
			PH_FRAME: begin
				if (byte_idx < 5) begin
					byte_idx++; o_mosi = frame_at(byte_idx);
				end else begin
					poll_cnt = 1; ph = PH_RESP;
				end
			end
			PH_RESP: begin
				if (!it.miso_byte[7] || poll_cnt >= at_least_one(cfg.response_polls))
					on_r1(it.miso_byte);
				else poll_cnt++;
			end
			PH_R7: begin
				reply_word = (reply_word << 8) | it.miso_byte;
				if (byte_idx < 3) byte_idx++;
				else begin
					v2 = (reply_word[15:0] == 16'h01AA);
					if (v2) diag |= 5'h02;
					attempt_cnt = 1; issue_cmd(6'd55, 0);
				end
			end
			PH_OCR: begin
				reply_word = (reply_word << 8) | it.miso_byte;
				if (byte_idx < 3) byte_idx++;
				else begin
					if (last_r1 == 0) diag |= 5'h10;
					if (last_r1 == 0 && reply_word[30]) begin
						kind = 2'd2; end_request(1'b1);
					end else begin
						kind = 2'd1; issue_cmd(6'd16, 512);
					end
				end
			end
			PH_RTOKEN: begin
				if (it.miso_byte != 8'hFF) begin
					if (it.miso_byte == 8'hFE) begin
						byte_idx = 0; ph = PH_RDATA;
					end else end_request(1'b0);
				end else if (poll_cnt >= at_least_one(cfg.token_polls)) end_request(1'b0);
				else poll_cnt++;
			end
			PH_RDATA: begin
				o_rdata = it.miso_byte; o_rvalid = 1;
				byte_idx++;
				if (byte_idx >= BLOCK_BYTES) begin
					byte_idx = 0; ph = PH_RCRC;
				end
			end
			PH_RCRC: begin
				if (byte_idx == 0) byte_idx = 1;
				else end_request(1'b1);
			end
			PH_WTOKEN: begin
				o_mosi = it.write_data; byte_idx = 1; o_take = (1 < BLOCK_BYTES);
				ph = PH_WDATA;
			end
			PH_WDATA: begin
				if (byte_idx < BLOCK_BYTES) begin
					o_mosi = it.write_data; byte_idx++;
					o_take = (byte_idx < BLOCK_BYTES);
				end else begin
					byte_idx = 0; ph = PH_WCRC;
				end
			end
			PH_WCRC: begin
				if (byte_idx == 0) byte_idx = 1;
				else ph = PH_WRESP;
			end
			PH_WRESP: begin
				if (it.miso_byte[4:0] != 5'h05) end_request(1'b0);
				else begin
					poll_cnt = 1; ph = PH_WBUSY;
				end
			end
			PH_WBUSY: begin
				if (it.miso_byte == 8'hFF) end_request(1'b1);
				else if (poll_cnt >= at_least_one(cfg.busy_polls)) end_request(1'b0);
				else poll_cnt++;
			end
			default: ph = PH_IDLE;
		endcase
		r.mosi_byte = o_mosi;
		r.select_low = (ph != PH_IDLE && ph != PH_BOOT);
		r.fast_clock = (kind != 0) && !in_init() && !o_slow;
		r.read_data = o_rdata;
		r.read_valid = o_rvalid;
		r.write_data_taken = o_take;
		r.done_res = o_done;
		r.success = o_ok;
		r.card_kind = kind;
		r.diag_bits = diag;
		r.reset_response = cmd0_r1;
		return r;
	endfunction

	task automatic queue_slot(in_item_t it);
		mosi_q.push_back(next_slot(it));
		slot_q.push_back(it);
	endtask

	function automatic logic [7:0] card_r1();
		case (cmd_idx)
			6'd0: return (card_profile == 4) ? 8'($urandom_range(0, 255)) : 8'h01;
			6'd8: return (card_profile <= 1) ? 8'h01 : 8'h05;
			6'd55: return 8'h01;
			6'd41: begin
				if (card_profile == 3) return 8'h05;
				return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'h01;
			end
			6'd1: return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'h01;
			6'd17, 6'd24: return ($urandom_range(0, 9) == 0) ? 8'h04 : 8'h00;
			default: return 8'h00;
		endcase
	endfunction

	// one slot of card behavior with random content and some noise
	task automatic queue_card_slot();
		in_item_t it;
		int unsigned pick;
		it.mode = MODE_SLOT;
		pick = $urandom_range(0, 9);
		it.block_address = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
		it.write_data = 8'($urandom);
		it.miso_byte = 8'($urandom);
		case (ph)
			PH_IDLE: begin
				pick = $urandom_range(0, 99);
				if (kind == 0 && pick < 80) it.mode = MODE_INIT;
				else if (pick < 15) it.mode = MODE_INIT;
				else if (pick < 55) it.mode = MODE_READ;
				else if (pick < 95) it.mode = MODE_WRITE;
				if (it.mode == MODE_INIT) card_profile = $urandom_range(0, 4);
			end
			PH_READY: if ($urandom_range(0, 3) != 0) it.miso_byte = 8'hFF;
			PH_RESP: if ($urandom_range(0, 3) != 0) it.miso_byte = card_r1();
				else it.miso_byte[7] = 1'b1;
			PH_R7: if ($urandom_range(0, 9) != 0)
				it.miso_byte = (byte_idx == 2) ? 8'h01 : (byte_idx == 3) ? 8'hAA : 8'h00;
			PH_OCR: if (byte_idx == 0) it.miso_byte = (card_profile == 0) ? 8'hC0 : 8'h80;
			PH_RTOKEN: begin
				pick = $urandom_range(0, 19);
				it.miso_byte = (pick < 12) ? 8'hFF : (pick < 19) ? 8'hFE : it.miso_byte;
			end
			PH_WRESP: if ($urandom_range(0, 6) != 0) it.miso_byte = 8'hE5;
			PH_WBUSY: it.miso_byte = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'h00;
			default: ;
		endcase
		if ($urandom_range(0, 99) < 5) it.miso_byte = 8'($urandom);
		if (ph != PH_IDLE && $urandom_range(0, 99) < 5) it.mode = mode_t'($urandom_range(0, 3));
		queue_slot(it);
	endtask

	task automatic run_slots(int n);
		int k;
		k = 0;
		while (k < n || ph != PH_IDLE) begin
			queue_card_slot();
			k++;
		end
		while (mosi_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(logic [7:0] rp, logic [19:0] rdy, logic [15:0] oc,
			logic [19:0] tk, logic [19:0] bz);
		logic [19:0] vals [5];
		vals = '{20'(rp), rdy, 20'(oc), tk, bz};
		for (int r = 0; r < 5; r++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(r);
			cfg_data <= vals[r];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg.response_polls = rp;
		cfg.ready_polls = rdy;
		cfg.op_cond_polls = oc;
		cfg.token_polls = tk;
		cfg.busy_polls = bz;
	endtask

	// input driver
	int in_gap = 0;
	logic in_burst = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.mode <= MODE_SLOT;
			in_ch.block_address <= '0;
			in_ch.miso_byte <= 8'hFF;
			in_ch.write_data <= '0;
		end else begin
			if ($urandom_range(0, 99) < 2) in_burst <= !in_burst;
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (slot_q.size() != 0) begin
					in_item_t it;
					it = slot_q.pop_front();
					in_ch.mode <= it.mode;
					in_ch.block_address <= it.block_address;
					in_ch.miso_byte <= it.miso_byte;
					in_ch.write_data <= it.write_data;
					in_ch.valid <= 1'b1;
					in_gap <= in_burst ? 0 : $urandom_range(0, 5);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// result monitor
	int out_stall = 0;
	logic out_burst = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) < 2) out_burst <= !out_burst;
			if (out_ch.valid && out_ch.ready) begin
				if (mosi_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none actual mosi %0h",
						$time, out_ch.mosi_byte);
					errors++;
				end else begin
					out_item_t w;
					w = mosi_q.pop_front();
					cmp_field("mosi_byte", w.mosi_byte, out_ch.mosi_byte);
					cmp_field("select_low", w.select_low, out_ch.select_low);
					cmp_field("fast_clock", w.fast_clock, out_ch.fast_clock);
					cmp_field("read_data", w.read_data, out_ch.read_data);
					cmp_field("read_valid", w.read_valid, out_ch.read_valid);
					cmp_field("write_data_taken", w.write_data_taken, out_ch.write_data_taken);
					cmp_field("done_res", w.done_res, out_ch.done_res);
					cmp_field("success", w.success, out_ch.success);
					cmp_field("card_kind", w.card_kind, out_ch.card_kind);
					cmp_field("diag_bits", w.diag_bits, out_ch.diag_bits);
					cmp_field("reset_response", w.reset_response, out_ch.reset_response);
				end
			end
			if (out_stall != 0) begin
				out_stall <= out_stall - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (out_ch.valid) out_stall <= out_burst ? 0 : $urandom_range(0, 5);
			end
		end
	end

	initial begin
		in_item_t it;
		cfg = '{8'd16, 20'd200000, 16'd2000, 20'd200000, 20'd500000};
		ph = PH_IDLE; poll_cnt = 0; attempt_cnt = 0; byte_idx = 0; cmd_arg = 0;
		cmd_idx = 0; reply_word = 0; last_r1 = 8'hFF; kind = 0; v2 = 0; diag = 0;
		cmd0_r1 = 8'hFF; card_profile = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// requests with no card known finish at once, failed
		it = '{MODE_READ, 32'hFFFF_FFFF, 8'h00, 8'hFF};
		queue_slot(it);
		it = '{MODE_WRITE, 32'h0, 8'hFF, 8'h00};
		queue_slot(it);
		it = '{MODE_SLOT, 32'hFFFF_FFFF, 8'h00, 8'hFF};
		queue_slot(it);
		it = '{MODE_SLOT, 32'h0, 8'hFF, 8'h00};
		queue_slot(it);
		// init with reset defaults, an sdhc card, then extreme-address requests
		card_profile = 0;
		it = '{MODE_INIT, 32'h0, 8'h00, 8'h00};
		queue_slot(it);
		while (ph != PH_IDLE) queue_card_slot();
		it = '{MODE_READ, 32'hFFFF_FFFF, 8'hFF, 8'h00};
		queue_slot(it);
		while (ph != PH_IDLE) queue_card_slot();
		it = '{MODE_WRITE, 32'h0, 8'hFF, 8'hA5};
		queue_slot(it);
		run_slots(0);

		set_regs(8'd4, 20'd3, 16'd3, 20'd6, 20'd6);
		run_slots(500);
		set_regs(8'd1, 20'd1, 16'd1, 20'd1, 20'd1);
		run_slots(400);
		set_regs(8'd0, 20'd0, 16'd0, 20'd0, 20'd0);
		run_slots(300);
		set_regs(8'd255, 20'hFFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
		run_slots(400);
		set_regs(8'd2, 20'd5, 16'd4, 20'd3, 20'd4);
		run_slots(350);

		repeat (20) @(posedge clk);
		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	initial begin
		#50ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
